[hdl/hct_pkg.sv]
// Shared types and constants for the heater/cooler thermostat.
// Used by hct_step and heater_cooler_thermostat_fsm; depends on nothing.
package hct_pkg;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_SET    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_MAX_SETPOINT     = 3'd0,
    REG_MIN_SETPOINT     = 3'd1,
    REG_SETPOINT_STEP    = 3'd2,
    REG_HYSTERESIS_BAND  = 3'd3,
    REG_INITIAL_SETPOINT = 3'd4,
    REG_TIMEOUT_PERIODS  = 3'd5
  } reg_idx_t;

  // press count at which plus/minus start stepping the set point
  localparam logic [1:0]  PRESS_ARMED = 2'd2;
  localparam logic [15:0] IDLE_MAX    = 16'hFFFF;
  localparam logic [7:0]  TEMP_MAX    = 8'hFF;

  localparam logic [7:0]  RST_MAX_SETPOINT     = 8'd75;
  localparam logic [7:0]  RST_MIN_SETPOINT     = 8'd35;
  localparam logic [4:0]  RST_SETPOINT_STEP    = 5'd5;
  localparam logic [4:0]  RST_HYSTERESIS_BAND  = 5'd5;
  localparam logic [7:0]  RST_INITIAL_SETPOINT = 8'd60;
  localparam logic [15:0] RST_TIMEOUT_PERIODS  = 16'd250;
  localparam logic [7:0]  RST_TARGET           = 8'd60;

  typedef struct packed {
    logic [7:0]  max_setpoint;
    logic [7:0]  min_setpoint;
    logic [4:0]  setpoint_step;
    logic [4:0]  hysteresis_band;
    logic [7:0]  initial_setpoint;
    logic [15:0] timeout_periods;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic        powered;
    logic [1:0]  press_count;
    logic [7:0]  setpoint;
    logic [7:0]  active_target;
    logic [7:0]  saved_target;
    logic        heater;
    logic        cooler;
    logic [15:0] idle_count;
  } state_t;

  typedef struct packed {
    logic       plus_press;
    logic       minus_press;
    logic       set_press;
    logic [7:0] avg_temp;
    logic       avg_valid;
  } item_t;

endpackage

[hdl/heater_cooler_thermostat_fsm.sv]
// Top level of the heater/cooler thermostat: stream ports, config registers,
// state register and result register. Depends on hct_pkg and hct_step.
//
// Usage:
//   Each transfer on the s_ channel is one update period: button press events
//   (plus, minus, set) and an optional averaged temperature sample, with
//   s_tuser marking the sample as fresh. Each period yields exactly one result
//   transfer on the m_ channel: drive outputs, mode, set point and target,
//   all taken after that period's update.
//   Configuration registers (limits, step, hysteresis band, initial set
//   point, timeout) are written over the cfg_ channel by index; cfg_ready is
//   always high. Write them only while no period is in flight.
//   Data path: a period accepted on the s_ channel sits in the input register;
//   the state update and result capture happen together as it moves into the
//   result register, which then shows it on m_tvalid.
//   Throughput: one period per cycle while the result stream is not stalled, as the
//   next-state logic between the input register and the result register is combinational.
//   Stall: when m_tready is low a valid result holds in the result register; the
//   input register still takes one more period if it is empty, then s_tready drops.
//   Reset (rst, synchronous): mode off, unpowered, drives off, set point and
//   targets 60, idle counter cleared, registers back to their defaults.
module heater_cooler_thermostat_fsm (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // plus_press, minus_press, set_press, avg_temp[7:0], zero pad
  input  logic        s_tuser,   // avg_valid
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // heater_on, cooler_on, op_mode[1:0], setpoint_out[7:0],
                                 // target_out[7:0], zero pad
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  hct_pkg::cfg_t   cfg;
  hct_pkg::state_t st;
  hct_pkg::state_t st_next;
  hct_pkg::item_t  in_item;
  logic            in_valid;
  logic            out_ready;
  logic            advance;
  logic [23:0]     result;

  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_setpoint     <= hct_pkg::RST_MAX_SETPOINT;
      cfg.min_setpoint     <= hct_pkg::RST_MIN_SETPOINT;
      cfg.setpoint_step    <= hct_pkg::RST_SETPOINT_STEP;
      cfg.hysteresis_band  <= hct_pkg::RST_HYSTERESIS_BAND;
      cfg.initial_setpoint <= hct_pkg::RST_INITIAL_SETPOINT;
      cfg.timeout_periods  <= hct_pkg::RST_TIMEOUT_PERIODS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (hct_pkg::reg_idx_t'(cfg_index))
        hct_pkg::REG_MAX_SETPOINT:     cfg.max_setpoint     <= cfg_data[7:0];
        hct_pkg::REG_MIN_SETPOINT:     cfg.min_setpoint     <= cfg_data[7:0];
        hct_pkg::REG_SETPOINT_STEP:    cfg.setpoint_step    <= cfg_data[4:0];
        hct_pkg::REG_HYSTERESIS_BAND:  cfg.hysteresis_band  <= cfg_data[4:0];
        hct_pkg::REG_INITIAL_SETPOINT: cfg.initial_setpoint <= cfg_data[7:0];
        hct_pkg::REG_TIMEOUT_PERIODS:  cfg.timeout_periods  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // handshake: result register frees up when empty or being taken
  assign out_ready = !m_tvalid || m_tready;
  assign advance   = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.plus_press  <= s_tdata[0];
      in_item.minus_press <= s_tdata[1];
      in_item.set_press   <= s_tdata[2];
      in_item.avg_temp    <= s_tdata[10:3];
      in_item.avg_valid   <= s_tuser;
    end
  end

  hct_step u_step (
    .cfg  (cfg),
    .cur  (st),
    .item (in_item),
    .nxt  (st_next)
  );

  // state register: advance once per period as it moves to the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode          <= hct_pkg::MODE_OFF;
      st.powered       <= 1'b0;
      st.press_count   <= '0;
      st.setpoint      <= hct_pkg::RST_TARGET;
      st.active_target <= hct_pkg::RST_TARGET;
      st.saved_target  <= hct_pkg::RST_TARGET;
      st.heater        <= 1'b0;
      st.cooler        <= 1'b0;
      st.idle_count    <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= {4'b0, st_next.active_target, st_next.setpoint, st_next.mode,
                 st_next.cooler, st_next.heater};
    end
  end

  assign m_tdata = result;

  // heater and cooler never drive together
  a_drives_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(st.heater && st.cooler))
    else $error("heater and cooler both on");

  // off mode exactly when unpowered
  a_off_unpowered: assert property (@(posedge clk) disable iff (rst)
    (st.mode == hct_pkg::MODE_OFF) == !st.powered)
    else $error("mode and power flag disagree");

  // drives stay off while switched off
  a_off_drives: assert property (@(posedge clk) disable iff (rst)
    (st.mode == hct_pkg::MODE_OFF) |-> (!st.heater && !st.cooler))
    else $error("drive on in off mode");

  // press count stops at the armed value
  a_press_range: assert property (@(posedge clk) disable iff (rst)
    st.press_count != 2'd3)
    else $error("press count overran");

  // state moves only when a period passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("state changed without a period");

endmodule

[hdl/hct_step.sv]
// Next-state logic for one update period of the thermostat.
// Depends on hct_pkg (cfg_t, state_t, item_t, mode_t).
module hct_step (
  input  hct_pkg::cfg_t   cfg,
  input  hct_pkg::state_t cur,
  input  hct_pkg::item_t  item,
  output hct_pkg::state_t nxt
);

  hct_pkg::state_t s;
  logic            any_press;
  logic            updown;
  logic [8:0]      sp_up;
  logic            heat_hit;
  logic            cool_hit;

  assign any_press = item.plus_press | item.minus_press | item.set_press;
  assign updown    = item.plus_press | item.minus_press;

  always_comb begin
    s = cur;

    // idle timeout
    if (s.mode == hct_pkg::MODE_SET && s.idle_count != hct_pkg::IDLE_MAX) begin
      s.idle_count = s.idle_count + 16'd1;
    end
    if (any_press) begin
      s.idle_count = '0;
    end
    if (s.mode == hct_pkg::MODE_SET && s.idle_count >= cfg.timeout_periods) begin
      s.mode        = hct_pkg::MODE_NORMAL;
      s.idle_count  = '0;
      s.press_count = '0;
    end

    // mode check
    if (updown && s.press_count != hct_pkg::PRESS_ARMED && s.powered) begin
      s.heater      = 1'b0;
      s.cooler      = 1'b0;
      s.mode        = hct_pkg::MODE_SET;
      s.press_count = s.press_count + 2'd1;
    end else if (item.set_press) begin
      if (!s.powered) begin
        s.mode    = hct_pkg::MODE_NORMAL;
        s.powered = 1'b1;
      end else begin
        s.active_target = s.saved_target;
        s.heater        = 1'b0;
        s.cooler        = 1'b0;
        s.idle_count    = '0;
        s.press_count   = '0;
        s.setpoint      = cfg.initial_setpoint;
        s.mode          = hct_pkg::MODE_OFF;
        s.powered       = 1'b0;
      end
    end

    // action of the resulting mode
    sp_up    = {1'b0, s.setpoint} + {4'b0, cfg.setpoint_step};
    heat_hit = ({1'b0, s.active_target} >= {4'b0, cfg.hysteresis_band}) &&
               (({1'b0, item.avg_temp} + {4'b0, cfg.hysteresis_band}) <=
                {1'b0, s.active_target});
    cool_hit = {1'b0, item.avg_temp} >=
               ({1'b0, s.active_target} + {4'b0, cfg.hysteresis_band});

    unique case (s.mode)
      hct_pkg::MODE_SET: begin
        s.saved_target  = s.setpoint;
        s.active_target = s.setpoint;
        if (item.plus_press && s.press_count == hct_pkg::PRESS_ARMED) begin
          if (s.setpoint < cfg.max_setpoint) begin
            s.setpoint = sp_up[8] ? hct_pkg::TEMP_MAX : sp_up[7:0];
          end
        end else if (item.minus_press && s.press_count == hct_pkg::PRESS_ARMED) begin
          if (s.setpoint > cfg.min_setpoint) begin
            s.setpoint = (s.setpoint > {3'b0, cfg.setpoint_step}) ?
                         s.setpoint - {3'b0, cfg.setpoint_step} : 8'd0;
          end
        end
      end
      hct_pkg::MODE_NORMAL: begin
        if (item.avg_valid) begin
          if (heat_hit) begin
            s.heater = 1'b1;
            s.cooler = 1'b0;
          end else if (cool_hit) begin
            s.heater = 1'b0;
            s.cooler = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    nxt = s;
  end

endmodule

[bench/heater_cooler_thermostat_fsm_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for heater_cooler_thermostat_fsm: directed table, then random phases.
// Depends on hct_pkg and the thermostat RTL; predicts every result in-line.
module heater_cooler_thermostat_fsm_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;   // margin after the last expected result
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 72;
  localparam int PLAN_LEN       = 31;

  // one result transfer, laid out as m_tdata[19:0] (heater in bit 0)
  typedef struct packed {
    logic [7:0]     target;
    logic [7:0]     setpoint;
    hct_pkg::mode_t mode;
    logic           cooler;
    logic           heater;
  } reading_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    hct_pkg::reg_idx_t idx;
    logic [15:0]       value;
    hct_pkg::item_t    period;
    logic              typed;   // want holds a hand-written expectation
    reading_t          want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  heater_cooler_thermostat_fsm u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the thermostat and its registers
  hct_pkg::state_t thermo;
  hct_pkg::cfg_t   regs;
  reading_t        pending_readings[$];
  int              mismatches;
  int              gap_pct;
  int              stall_pct;
  int              stall_left;
  int              quiet_cycles;
  reading_t        seen_want;
  reading_t        seen_got;

  // Directed table. Item columns: plus, minus, set, avg_temp, avg_valid.
  // Expectation columns: target, setpoint, mode, cooler, heater.
  row_t plan [0:PLAN_LEN-1] = '{
    // unpowered: no control, plus ignored
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b0, 8'd255, 1'b1}, 1'b1,
      '{8'd60, 8'd60, hct_pkg::MODE_OFF, 1'b0, 1'b0}},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b1, 1'b0, 1'b0, 8'd0, 1'b1}, 1'b1,
      '{8'd60, 8'd60, hct_pkg::MODE_OFF, 1'b0, 1'b0}},
    // power up, then heat / cool / hold around 60 with band 5
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b1, 8'd0, 1'b1}, 1'b1,
      '{8'd60, 8'd60, hct_pkg::MODE_NORMAL, 1'b0, 1'b1}},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b0, 8'd255, 1'b1}, 1'b1,
      '{8'd60, 8'd60, hct_pkg::MODE_NORMAL, 1'b1, 1'b0}},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b0, 8'd55, 1'b1}, 1'b1,
      '{8'd60, 8'd60, hct_pkg::MODE_NORMAL, 1'b0, 1'b1}},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b0, 8'd255, 1'b0}, 1'b1,
      '{8'd60, 8'd60, hct_pkg::MODE_NORMAL, 1'b0, 1'b1}},
    // set mode: first press enters set mode, later presses step up to the max
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b1, 1'b0, 1'b0, 8'd0, 1'b1}, 1'b1,
      '{8'd60, 8'd60, hct_pkg::MODE_SET, 1'b0, 1'b0}},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b1, 1'b0, 1'b0, 8'd0, 1'b0}, 1'b1,
      '{8'd60, 8'd65, hct_pkg::MODE_SET, 1'b0, 1'b0}},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b1, 1'b0, 1'b0, 8'd0, 1'b0}, 1'b1,
      '{8'd65, 8'd70, hct_pkg::MODE_SET, 1'b0, 1'b0}},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b1, 1'b0, 1'b0, 8'd0, 1'b0}, 1'b1,
      '{8'd70, 8'd75, hct_pkg::MODE_SET, 1'b0, 1'b0}},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b1, 1'b0, 1'b0, 8'd0, 1'b0}, 1'b1,
      '{8'd75, 8'd75, hct_pkg::MODE_SET, 1'b0, 1'b0}},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b1, 1'b0, 8'd0, 1'b0}, 1'b1,
      '{8'd75, 8'd70, hct_pkg::MODE_SET, 1'b0, 1'b0}},
    // both buttons: plus wins
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b1, 1'b1, 1'b0, 8'd0, 1'b0}, 1'b1,
      '{8'd70, 8'd75, hct_pkg::MODE_SET, 1'b0, 1'b0}},
    // switch off: target reloads from saved, set point from initial
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b1, 8'd0, 1'b0}, 1'b1,
      '{8'd70, 8'd60, hct_pkg::MODE_OFF, 1'b0, 1'b0}},
    // shortest timeout, widest step and band
    '{ROW_CFG, hct_pkg::REG_TIMEOUT_PERIODS,  16'd1,   '0, 1'b0, '0},
    '{ROW_CFG, hct_pkg::REG_SETPOINT_STEP,    16'd31,  '0, 1'b0, '0},
    '{ROW_CFG, hct_pkg::REG_MAX_SETPOINT,     16'd250, '0, 1'b0, '0},
    '{ROW_CFG, hct_pkg::REG_MIN_SETPOINT,     16'd20,  '0, 1'b0, '0},
    '{ROW_CFG, hct_pkg::REG_HYSTERESIS_BAND,  16'd31,  '0, 1'b0, '0},
    '{ROW_CFG, hct_pkg::REG_INITIAL_SETPOINT, 16'd240, '0, 1'b0, '0},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b1, 8'd0, 1'b1}, 1'b0, '0},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b1, 1'b0, 8'd0, 1'b1}, 1'b0, '0},
    // minus steps down past the minimum and floors at zero
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b1, 1'b0, 8'd0, 1'b1}, 1'b0, '0},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b1, 1'b0, 8'd0, 1'b1}, 1'b0, '0},
    // idle period times out of set mode
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b0, 8'd0, 1'b1}, 1'b0, '0},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b1, 1'b0, 8'd0, 1'b1}, 1'b0, '0},
    // target 0 below the band: cold sample must not wrap into heating
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b0, 8'd0, 1'b1}, 1'b0, '0},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b1, 8'd0, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b0, 1'b0, 1'b1, 8'd0, 1'b0}, 1'b0, '0},
    // step from 240 overshoots the max and saturates at 255
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b1, 1'b0, 1'b0, 8'd0, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, hct_pkg::REG_MAX_SETPOINT, 16'd0, '{1'b1, 1'b0, 1'b0, 8'd0, 1'b0}, 1'b0, '0}
  };

  task automatic thermo_reset();
    regs.max_setpoint     = hct_pkg::RST_MAX_SETPOINT;
    regs.min_setpoint     = hct_pkg::RST_MIN_SETPOINT;
    regs.setpoint_step    = hct_pkg::RST_SETPOINT_STEP;
    regs.hysteresis_band  = hct_pkg::RST_HYSTERESIS_BAND;
    regs.initial_setpoint = hct_pkg::RST_INITIAL_SETPOINT;
    regs.timeout_periods  = hct_pkg::RST_TIMEOUT_PERIODS;
    thermo               = '0;
    thermo.mode          = hct_pkg::MODE_OFF;
    thermo.setpoint      = hct_pkg::RST_TARGET;
    thermo.active_target = hct_pkg::RST_TARGET;
    thermo.saved_target  = hct_pkg::RST_TARGET;
  endtask

  // Advance the shadow thermostat by one update period and return its outputs.
  // Order: idle timeout, then mode check, then the action of the resulting mode.
  function automatic reading_t thermo_step(hct_pkg::item_t p);
    reading_t r;
    int sp;
    int step;
    int tgt;
    int band;
    int temp;
    sp   = thermo.setpoint;
    step = regs.setpoint_step;
    tgt  = thermo.active_target;
    band = regs.hysteresis_band;
    temp = p.avg_temp;

    // idle timeout: counts only in set mode, any press clears it
    if (thermo.mode == hct_pkg::MODE_SET && thermo.idle_count != hct_pkg::IDLE_MAX)
      thermo.idle_count = thermo.idle_count + 16'd1;
    if (p.plus_press || p.minus_press || p.set_press)
      thermo.idle_count = '0;
    if (thermo.mode == hct_pkg::MODE_SET && thermo.idle_count >= regs.timeout_periods) begin
      thermo.mode        = hct_pkg::MODE_NORMAL;
      thermo.idle_count  = '0;
      thermo.press_count = '0;
    end

    // mode check: arrow presses enter set mode until armed, set press powers on/off
    if ((p.plus_press || p.minus_press) && thermo.press_count != hct_pkg::PRESS_ARMED
        && thermo.powered) begin
      thermo.heater      = 1'b0;
      thermo.cooler      = 1'b0;
      thermo.mode        = hct_pkg::MODE_SET;
      thermo.press_count = thermo.press_count + 2'd1;
    end else if (p.set_press) begin
      if (!thermo.powered) begin
        thermo.mode    = hct_pkg::MODE_NORMAL;
        thermo.powered = 1'b1;
      end else begin
        thermo.active_target = thermo.saved_target;
        thermo.heater        = 1'b0;
        thermo.cooler        = 1'b0;
        thermo.idle_count    = '0;
        thermo.press_count   = '0;
        thermo.setpoint      = regs.initial_setpoint;
        thermo.mode          = hct_pkg::MODE_OFF;
        thermo.powered       = 1'b0;
      end
    end

    case (thermo.mode)
      hct_pkg::MODE_SET: begin
        // latch the set point before stepping it
        sp = thermo.setpoint;
        thermo.saved_target  = thermo.setpoint;
        thermo.active_target = thermo.setpoint;
        if (p.plus_press && thermo.press_count == hct_pkg::PRESS_ARMED) begin
          if (thermo.setpoint < regs.max_setpoint)
            sp = (sp + step > 255) ? 255 : sp + step;
        end else if (p.minus_press && thermo.press_count == hct_pkg::PRESS_ARMED) begin
          if (thermo.setpoint > regs.min_setpoint)
            sp = (sp > step) ? sp - step : 0;
        end
        thermo.setpoint = sp[7:0];
      end
      hct_pkg::MODE_NORMAL: begin
        // band limits in full integers, no wrap
        tgt = thermo.active_target;
        if (p.avg_valid) begin
          if (temp <= tgt - band) begin
            thermo.heater = 1'b1;
            thermo.cooler = 1'b0;
          end else if (temp >= tgt + band) begin
            thermo.heater = 1'b0;
            thermo.cooler = 1'b1;
          end
        end
      end
      default: ;
    endcase

    r.target   = thermo.active_target;
    r.setpoint = thermo.setpoint;
    r.mode     = thermo.mode;
    r.cooler   = thermo.cooler;
    r.heater   = thermo.heater;
    return r;
  endfunction

  // Random period: mostly powered button sequences, temperatures near the band edges half the time
  function automatic hct_pkg::item_t pick_period();
    hct_pkg::item_t p;
    int r;
    int t;
    int band;
    band = regs.hysteresis_band;
    r    = $urandom_range(0, 99);
    p    = '0;
    if (!thermo.powered && $urandom_range(0, 1) == 1)
      p.set_press = 1'b1;
    else if (r < 5)
      p.set_press = 1'b1;
    else if (r < 45)
      p.plus_press = 1'b1;
    else if (r < 70)
      p.minus_press = 1'b1;
    else if (r < 75)
      {p.plus_press, p.minus_press} = 2'b11;
    else if (r < 78)
      {p.plus_press, p.minus_press, p.set_press} = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 1) == 1) begin
      t = int'(thermo.active_target) + int'($urandom_range(0, 2 * band + 4)) - (band + 2);
      t = (t < 0) ? 0 : (t > 255) ? 255 : t;
      p.avg_temp = t[7:0];
    end else begin
      p.avg_temp = 8'($urandom_range(0, 255));
    end
    p.avg_valid = ($urandom_range(0, 3) != 0);
    return p;
  endfunction

  // Drive one period; predict on the accepting edge
  task automatic send_period(input hct_pkg::item_t p, input logic typed, input reading_t want);
    reading_t r;
    int burst;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      burst = $urandom_range(1, 12);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (burst - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tdata  = {5'b0, p.avg_temp, p.set_press, p.minus_press, p.plus_press};
    s_tuser  = p.avg_valid;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    r = thermo_step(p);
    pending_readings.push_back(typed ? want : r);
  endtask

  task automatic write_reg(input hct_pkg::reg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hct_pkg::REG_MAX_SETPOINT:     regs.max_setpoint     = value[7:0];
      hct_pkg::REG_MIN_SETPOINT:     regs.min_setpoint     = value[7:0];
      hct_pkg::REG_SETPOINT_STEP:    regs.setpoint_step    = value[4:0];
      hct_pkg::REG_HYSTERESIS_BAND:  regs.hysteresis_band  = value[4:0];
      hct_pkg::REG_INITIAL_SETPOINT: regs.initial_setpoint = value[7:0];
      hct_pkg::REG_TIMEOUT_PERIODS:  regs.timeout_periods  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, let every expected result arrive, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Result sink: random stall bursts, sampled with the DUT at the rising edge
  always @(negedge clk) begin
    if (rst) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(1, 12) - 1;
    end else begin
      m_tready   <= 1'b1;
    end
  end

  // Compare every result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: result 0x%06h with nothing expected", $time, m_tdata);
      end else begin
        seen_want = pending_readings.pop_front();
        seen_got  = reading_t'(m_tdata[19:0]);
        check_field("heater_on",    seen_want.heater,   seen_got.heater);
        check_field("cooler_on",    seen_want.cooler,   seen_got.cooler);
        check_field("op_mode",      seen_want.mode,     seen_got.mode);
        check_field("setpoint_out", seen_want.setpoint, seen_got.setpoint);
        check_field("target_out",   seen_want.target,   seen_got.target);
      end
    end
  end

  // Watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [15:0] phase_cfg [6];
    hct_pkg::item_t p;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    m_tready     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    stall_left   = 0;
    gap_pct      = 20;
    stall_pct    = 20;
    thermo_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_period(plan[i].period, plan[i].typed, plan[i].want);
      end
    end

    // random phases: low extremes, high extremes, then random settings
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        phase_cfg = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1};
      end else if (ph == 1) begin
        phase_cfg = '{16'd255, 16'd255, 16'd31, 16'd31, 16'd255, 16'd65535};
      end else begin
        phase_cfg[hct_pkg::REG_MAX_SETPOINT] = 16'($urandom_range(0, 255));
        phase_cfg[hct_pkg::REG_MIN_SETPOINT] = ($urandom_range(0, 3) != 0) ?
          16'($urandom_range(0, phase_cfg[hct_pkg::REG_MAX_SETPOINT])) :
          16'($urandom_range(0, 255));
        phase_cfg[hct_pkg::REG_SETPOINT_STEP]    = 16'($urandom_range(1, 31));
        phase_cfg[hct_pkg::REG_HYSTERESIS_BAND]  = 16'($urandom_range(0, 31));
        phase_cfg[hct_pkg::REG_INITIAL_SETPOINT] = 16'($urandom_range(0, 255));
        phase_cfg[hct_pkg::REG_TIMEOUT_PERIODS]  = ($urandom_range(0, 9) < 7) ?
          16'($urandom_range(1, 12)) : 16'($urandom_range(13, 300));
      end
      // phase 2 and the last phase run without any idling
      if (ph == 2 || ph == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(5, 40);
        stall_pct = $urandom_range(5, 40);
      end
      drain();
      for (int k = 0; k < 6; k++)
        write_reg(hct_pkg::reg_idx_t'(k), phase_cfg[k]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        p = pick_period();
        send_period(p, 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0 && pending_readings.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
hdl/hct_pkg.sv
hdl/hct_step.sv
hdl/heater_cooler_thermostat_fsm.sv
bench/heater_cooler_thermostat_fsm_tb.sv
